// ===== hdl/u8u16_pkg.sv =====
// shared types and constants for the utf-8 to utf-16 transcoder
// no dependencies; imported by every module in hdl
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned UNIT_W = 16;
    localparam int unsigned ACC_W = 21;
    localparam int unsigned CONT_BITS = 6;
    localparam int unsigned IN_TDATA_W = 8;
    localparam int unsigned OUT_TDATA_W = 24;

    localparam logic [ACC_W-1:0] SURR_LOW_BOUND = 21'h00D800;
    localparam logic [ACC_W-1:0] SURR_HIGH_BOUND = 21'h00DFFF;
    localparam logic [ACC_W-1:0] CODE_MAX = 21'h10FFFF;
    localparam logic [ACC_W-1:0] SUPPLEMENTARY_BASE = 21'h010000;
    localparam logic [UNIT_W-1:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0] LOW_SURR_BASE = 16'hDC00;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              is_error;
        logic              last_of_run;
        logic              string_end;
    } result_t;

    // results produced by one decoded byte, first goes out first
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== hdl/u8u16_decoder.sv =====
// input register, sequence state and per-byte decode of utf-8 into utf-16 units
// depends on u8u16_pkg; feeds u8u16_out_fifo
`timescale 1ns / 1ps

module u8u16_decoder
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                in_byte,
    input  logic                      in_eos,
    input  logic                      room,
    output u8u16_pkg::push_t          push
);
    import u8u16_pkg::*;

    typedef enum logic [5:0] {
        LEAD_ASCII = 6'b000001,
        LEAD_CONT  = 6'b000010,
        LEAD_TWO   = 6'b000100,
        LEAD_THREE = 6'b001000,
        LEAD_FOUR  = 6'b010000,
        LEAD_BAD   = 6'b100000
    } lead_t;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              eos_reg;

    logic [1:0]        remaining_reg, remaining_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              dropping_reg, dropping_next;

    logic              fire;
    lead_t             lead;
    logic [ACC_W-1:0]  acc_shift;
    logic [1:0]        remaining_dec;
    logic [ACC_W-1:0]  offset;
    logic [19:0]       v;
    push_t             push_c;
    result_t           err_res;

    assign fire     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            remaining_reg <= 2'd0;
            acc_reg       <= '0;
            dropping_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                remaining_reg <= remaining_next;
                acc_reg       <= acc_next;
                dropping_reg  <= dropping_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
            eos_reg  <= in_eos;
        end
    end

    always_comb
    begin
        priority casez (byte_reg)
            8'b0???????: lead = LEAD_ASCII;
            8'b10??????: lead = LEAD_CONT;
            8'b110?????: lead = LEAD_TWO;
            8'b1110????: lead = LEAD_THREE;
            8'b11110???: lead = LEAD_FOUR;
            default:     lead = LEAD_BAD;
        endcase
    end

    assign acc_shift     = {acc_reg[ACC_W-CONT_BITS-1:0], byte_reg[CONT_BITS-1:0]};
    assign remaining_dec = remaining_reg - 2'd1;
    assign offset        = acc_shift - SUPPLEMENTARY_BASE;
    assign v             = offset[19:0];

    always_comb
    begin
        err_res.code_unit   = '0;
        err_res.is_error    = 1'b1;
        err_res.last_of_run = 1'b1;
        err_res.string_end  = eos_reg;
    end

    always_comb
    begin
        remaining_next = remaining_reg;
        acc_next       = acc_reg;
        dropping_next  = dropping_reg;
        push_c.count   = 2'd0;
        push_c.first   = err_res;
        push_c.second  = err_res;

        if (dropping_reg)
        begin
            if (eos_reg)
            begin
                dropping_next  = 1'b0;
                remaining_next = 2'd0;
                acc_next       = '0;
            end
        end
        else if (remaining_reg == 2'd0)
        begin
            unique case (lead)
                LEAD_ASCII:
                begin
                    push_c.count              = 2'd1;
                    push_c.first.code_unit    = {8'd0, byte_reg};
                    push_c.first.is_error     = 1'b0;
                end
                LEAD_CONT, LEAD_BAD:
                begin
                    push_c.count  = 2'd1;
                    acc_next      = '0;
                    dropping_next = !eos_reg;
                end
                LEAD_TWO, LEAD_THREE, LEAD_FOUR:
                begin
                    if (eos_reg)
                    begin
                        push_c.count = 2'd1;
                        acc_next     = '0;
                    end
                    else if (lead == LEAD_TWO)
                    begin
                        acc_next       = {16'd0, byte_reg[4:0]};
                        remaining_next = 2'd1;
                    end
                    else if (lead == LEAD_THREE)
                    begin
                        acc_next       = {17'd0, byte_reg[3:0]};
                        remaining_next = 2'd2;
                    end
                    else
                    begin
                        acc_next       = {18'd0, byte_reg[2:0]};
                        remaining_next = 2'd3;
                    end
                end
                default:
                begin
                    push_c.count = 2'd0;
                end
            endcase
        end
        else if (byte_reg[7:6] != 2'b10)
        begin
            push_c.count   = 2'd1;
            remaining_next = 2'd0;
            acc_next       = '0;
            dropping_next  = !eos_reg;
        end
        else if (remaining_dec != 2'd0)
        begin
            if (eos_reg)
            begin
                push_c.count   = 2'd1;
                remaining_next = 2'd0;
                acc_next       = '0;
            end
            else
            begin
                remaining_next = remaining_dec;
                acc_next       = acc_shift;
            end
        end
        else
        begin
            remaining_next = 2'd0;
            acc_next       = '0;
            if ((acc_shift >= SURR_LOW_BOUND && acc_shift <= SURR_HIGH_BOUND)
                || acc_shift > CODE_MAX)
            begin
                push_c.count  = 2'd1;
                dropping_next = !eos_reg;
            end
            else if (acc_shift < SUPPLEMENTARY_BASE)
            begin
                push_c.count           = 2'd1;
                push_c.first.code_unit = acc_shift[UNIT_W-1:0];
                push_c.first.is_error  = 1'b0;
            end
            else
            begin
                push_c.count                = 2'd2;
                push_c.first.code_unit      = HIGH_SURR_BASE + {6'd0, v[19:10]};
                push_c.first.is_error       = 1'b0;
                push_c.first.last_of_run    = 1'b0;
                push_c.first.string_end     = 1'b0;
                push_c.second.code_unit     = LOW_SURR_BASE + {6'd0, v[9:0]};
                push_c.second.is_error      = 1'b0;
            end
        end
    end

    always_comb
    begin
        push = push_c;
        if (!fire)
        begin
            push.count = 2'd0;
        end
    end

endmodule

// ===== hdl/u8u16_out_fifo.sv =====
// small queue taking up to two results per cycle, giving one if ready
// depends on u8u16_pkg; drives the master-side stream of the top level
`timescale 1ns / 1ps

module u8u16_out_fifo
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  u8u16_pkg::push_t     push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output u8u16_pkg::result_t   out_res
);
    import u8u16_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] wr_ptr_inc2;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == LAST_PTR)
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign room      = count_reg <= ROOM_MAX;
    assign out_valid = count_reg != '0;
    assign out_res   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign wr_ptr_inc  = ptr_inc(wr_ptr_reg);
    assign wr_ptr_inc2 = ptr_inc(wr_ptr_inc);

    always_comb
    begin
        unique case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = wr_ptr_inc2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_inc] <= push.second;
        end
    end

endmodule

// ===== hdl/utf8_to_utf16_transcoder.sv =====
// utf-8 byte stream in, utf-16 code units out; one byte per transaction
// path: a taken byte is held in the input register and its results are written into the result queue, which offers them
// throughput: one byte per cycle while the result queue has room; a surrogate pair gives two code units on the output
// reset: rst_n clears the sequence state, the input register and the result queue
// depends on u8u16_pkg, u8u16_decoder and u8u16_out_fifo
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder
#(
    parameter int unsigned FIFO_DEPTH = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [u8u16_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // data_byte
    input  logic                              s_axis_tlast,  // end_of_string
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [u8u16_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // code_unit, last_of_run, zeros
    output logic                              m_axis_tuser,  // is_error
    output logic                              m_axis_tlast   // string_end
);
    import u8u16_pkg::*;

    push_t   push;
    logic    room;
    result_t out_res;

    u8u16_decoder u_decoder
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_eos   (s_axis_tlast),
        .room     (room),
        .push     (push)
    );

    u8u16_out_fifo #(.DEPTH(FIFO_DEPTH)) u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {7'd0, out_res.last_of_run, out_res.code_unit};
    assign m_axis_tuser = out_res.is_error;
    assign m_axis_tlast = out_res.string_end;

endmodule

// ===== sim/tb_top.sv =====
// testbench for utf8_to_utf16_transcoder: directed strings, then random utf-8 strings
// expected units: from typed rows, else from a behavioural decoder inside this file
// depends on hdl/u8u16_pkg.sv and hdl/utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps

module tb_top;

    import u8u16_pkg::*;

    localparam logic [20:0] SURR_FIRST = 21'h00D800;
    localparam logic [20:0] SURR_LAST = 21'h00DFFF;
    localparam logic [20:0] UNICODE_TOP = 21'h10FFFF;
    localparam logic [20:0] PLANE1_BASE = 21'h010000;
    localparam logic [15:0] HI_SURR = 16'hD800;
    localparam logic [15:0] LO_SURR = 16'hDC00;

    localparam int STRING_BYTE_TARGET = 1850;
    localparam int QUIET_FROM = 1550;
    localparam int SQUEEZE_AT = 700;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_flag;
        logic       typed;
        result_t    want;
    } stim_row_t;

    localparam logic TYPED = 1'b1;
    localparam logic PREDICT = 1'b0;
    localparam result_t NONE = '0;
    localparam result_t BAD_AT_END = {16'h0000, 1'b1, 1'b1, 1'b1};
    localparam result_t BAD_MID = {16'h0000, 1'b1, 1'b1, 1'b0};

    // extremes, every error kind, dropping and the string-end cases
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        {8'h00, 1'b1, TYPED, {16'h0000, 1'b0, 1'b1, 1'b1}},
        {8'h7F, 1'b1, TYPED, {16'h007F, 1'b0, 1'b1, 1'b1}},
        {8'h80, 1'b1, TYPED, BAD_AT_END},
        {8'hFF, 1'b1, TYPED, BAD_AT_END},
        {8'hF8, 1'b0, TYPED, BAD_MID},
        {8'h41, 1'b0, PREDICT, NONE},
        {8'hC3, 1'b1, PREDICT, NONE},
        {8'hC3, 1'b0, PREDICT, NONE},
        {8'hA9, 1'b1, PREDICT, NONE},
        {8'hC3, 1'b0, PREDICT, NONE},
        {8'h41, 1'b1, TYPED, BAD_AT_END},
        {8'hE2, 1'b0, PREDICT, NONE},
        {8'h82, 1'b1, TYPED, BAD_AT_END},
        {8'hED, 1'b0, PREDICT, NONE},
        {8'hA0, 1'b0, PREDICT, NONE},
        {8'h80, 1'b1, TYPED, BAD_AT_END},
        {8'hF4, 1'b0, PREDICT, NONE},
        {8'h90, 1'b0, PREDICT, NONE},
        {8'h80, 1'b0, PREDICT, NONE},
        {8'h80, 1'b1, TYPED, BAD_AT_END},
        {8'hF4, 1'b0, PREDICT, NONE},
        {8'h8F, 1'b0, PREDICT, NONE},
        {8'hBF, 1'b0, PREDICT, NONE},
        {8'hBF, 1'b1, PREDICT, NONE},
        {8'hF0, 1'b1, TYPED, BAD_AT_END}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic        s_axis_tlast;   // end_of_string
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // code_unit, last_of_run, zeros
    logic        m_axis_tuser;   // is_error
    logic        m_axis_tlast;   // string_end

    // decoder state
    logic [1:0]  cont_left;
    logic [20:0] cp_acc;
    logic        skipping;

    result_t     units_due[$];
    logic [7:0]  string_bytes[$];
    int          mismatches = 0;
    int          bytes_sent;
    int          quiet_cycles = 0;
    bit          idle_on;
    bit          squeeze_req;

    utf8_to_utf16_transcoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int reject_string(input logic eos, output result_t r);
        cont_left = 2'd0;
        cp_acc = '0;
        skipping = !eos;
        r = {16'h0000, 1'b1, 1'b1, eos};
        return 1;
    endfunction

    function automatic int decode_byte(input logic [7:0] b, input logic eos,
                                       output result_t r0, output result_t r1);
        int unsigned lead;
        logic [20:0] cp;
        logic [20:0] offset;
        r0 = '0;
        r1 = '0;
        if (skipping)
        begin
            if (eos)
            begin
                skipping = 1'b0;
                cont_left = 2'd0;
                cp_acc = '0;
            end
            return 0;
        end
        if (cont_left == 2'd0)
        begin
            casez (b)
                8'b0???????: lead = 0;
                8'b10??????: lead = 1;
                8'b110?????: lead = 2;
                8'b1110????: lead = 3;
                8'b11110???: lead = 4;
                default:     lead = 5;
            endcase
            if (lead == 0)
            begin
                r0 = {8'h00, b, 1'b0, 1'b1, eos};
                return 1;
            end
            if (lead == 1 || lead == 5 || eos)
                return reject_string(eos, r0);
            cp_acc = 21'(b & (8'h7F >> lead));
            cont_left = 2'(lead - 1);
            return 0;
        end
        if (b[7:6] != 2'b10)
            return reject_string(eos, r0);
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left != 2'd0)
        begin
            if (eos)
                return reject_string(eos, r0);
            return 0;
        end
        cp = cp_acc;
        cp_acc = '0;
        if ((cp >= SURR_FIRST && cp <= SURR_LAST) || cp > UNICODE_TOP)
            return reject_string(eos, r0);
        if (cp < PLANE1_BASE)
        begin
            r0 = {cp[15:0], 1'b0, 1'b1, eos};
            return 1;
        end
        offset = cp - PLANE1_BASE;
        r0 = {HI_SURR + 16'(offset[19:10]), 1'b0, 1'b0, 1'b0};
        r1 = {LO_SURR + 16'(offset[9:0]), 1'b0, 1'b1, eos};
        return 2;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                             input result_t typed_want);
        result_t r0;
        result_t r1;
        int n;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eos;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        n = decode_byte(b, eos, r0, r1);
        if (typed)
            units_due.insert(units_due.size(), typed_want);
        else
        begin
            if (n > 0)
                units_due.insert(units_due.size(), r0);
            if (n > 1)
                units_due.insert(units_due.size(), r1);
        end
        bytes_sent++;
    endtask

    // sender
    initial
    begin
        int unsigned kind;
        int nbytes;
        int cut;
        logic [20:0] cp;
        bit squeezed;
        squeezed = 0;
        cont_left = 2'd0;
        cp_acc = '0;
        skipping = 1'b0;
        bytes_sent = 0;
        idle_on = 1;
        squeeze_req = 0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].data_byte, DIRECTED_ROWS[i].end_flag,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        while (bytes_sent < STRING_BYTE_TARGET)
        begin
            string_bytes.delete();
            repeat ($urandom_range(1, 6))
            begin
                kind = $urandom_range(0, 99);
                cut = 0;
                nbytes = 0;
                if (kind < 30)
                begin
                    cp = 21'($urandom_range(0, 'h7F));
                    nbytes = 1;
                end
                else if (kind < 45)
                begin
                    cp = 21'($urandom_range('h80, 'h7FF));
                    nbytes = 2;
                end
                else if (kind < 60)
                begin
                    cp = 21'($urandom_range('h800, 'hFFFF));
                    nbytes = 3;
                end
                else if (kind < 75)
                begin
                    cp = 21'($urandom_range('h10000, 'h10FFFF));
                    nbytes = 4;
                end
                else if (kind < 80)
                begin
                    // overlong forms decode to their value
                    cp = 21'($urandom_range(0, 'h7FF));
                    nbytes = $urandom_range(2, 4);
                end
                else if (kind < 84)
                begin
                    cp = 21'($urandom_range('hD800, 'hDFFF));
                    nbytes = 3;
                end
                else if (kind < 88)
                begin
                    cp = 21'($urandom_range('h110000, 'h1FFFFF));
                    nbytes = 4;
                end
                else if (kind < 92)
                    string_bytes.insert(string_bytes.size(), 8'($urandom_range(0, 255)));
                else if (kind < 96)
                begin
                    // sequence cut short
                    nbytes = $urandom_range(2, 4);
                    cp = 21'($urandom_range(0, 'h1FFFFF)) >> (6 * (4 - nbytes));
                    cut = $urandom_range(1, nbytes - 1);
                end
                else if (kind < 98)
                    string_bytes.insert(string_bytes.size(),
                                        8'($urandom_range('h80, 'hBF)));
                else
                    string_bytes.insert(string_bytes.size(),
                                        8'($urandom_range('hF8, 'hFF)));
                case (nbytes)
                    1: string_bytes.insert(string_bytes.size(), {1'b0, cp[6:0]});
                    2:
                    begin
                        string_bytes.insert(string_bytes.size(), {3'b110, cp[10:6]});
                        string_bytes.insert(string_bytes.size(), {2'b10, cp[5:0]});
                    end
                    3:
                    begin
                        string_bytes.insert(string_bytes.size(), {4'b1110, cp[15:12]});
                        string_bytes.insert(string_bytes.size(), {2'b10, cp[11:6]});
                        string_bytes.insert(string_bytes.size(), {2'b10, cp[5:0]});
                    end
                    4:
                    begin
                        string_bytes.insert(string_bytes.size(), {5'b11110, cp[20:18]});
                        string_bytes.insert(string_bytes.size(), {2'b10, cp[17:12]});
                        string_bytes.insert(string_bytes.size(), {2'b10, cp[11:6]});
                        string_bytes.insert(string_bytes.size(), {2'b10, cp[5:0]});
                    end
                    default: ;
                endcase
                repeat (cut) void'(string_bytes.pop_back());
            end
            if (!squeezed && bytes_sent >= SQUEEZE_AT)
            begin
                squeeze_req = 1;
                squeezed = 1;
            end
            idle_on = bytes_sent < QUIET_FROM;
            foreach (string_bytes[i])
                send_byte(string_bytes[i], i == string_bytes.size() - 1, PREDICT, NONE);
        end
        s_axis_tvalid <= 1'b0;

        while (units_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0 && units_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver, with one long hold-off to back the block up
    initial
    begin
        bit held_off;
        held_off = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !held_off)
            begin
                held_off = 1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // output checking, one transaction per edge
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (units_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected unit, expected none, got %h/%b/%b/%b", $time,
                             m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[16], m_axis_tlast);
            end
            else
            begin
                want = units_due.pop_front();
                if (m_axis_tdata[15:0] !== want.code_unit || m_axis_tuser !== want.is_error
                    || m_axis_tdata[16] !== want.last_of_run
                    || m_axis_tlast !== want.string_end || m_axis_tdata[23:17] !== 7'd0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: mismatch, expected %h/%b/%b/%b pad 00, got %h/%b/%b/%b pad %h",
                                 $time, want.code_unit, want.is_error, want.last_of_run,
                                 want.string_end, m_axis_tdata[15:0], m_axis_tuser,
                                 m_axis_tdata[16], m_axis_tlast, m_axis_tdata[23:17]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
